// ===== hw/rtl/key_value_spec_tokenizer_unit_macros.svh =====
// Assertion helpers for the tokenizer RTL.
// Each use expects clk and rst_n in scope.
`ifndef KEY_VALUE_SPEC_TOKENIZER_UNIT_MACROS_SVH
`define KEY_VALUE_SPEC_TOKENIZER_UNIT_MACROS_SVH

// Same-cycle implication.
`define KVST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KVST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kvst_pkg.sv =====
`default_nettype none

package kvst_pkg;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] ROLE_NONE  = 2'd0;
  localparam logic [1:0] ROLE_KEY   = 2'd1;
  localparam logic [1:0] ROLE_VALUE = 2'd2;

  typedef enum logic [2:0] {
    MODE_SKIP   = 3'd0,
    MODE_KEY    = 3'd1,
    MODE_VSTART = 3'd2,
    MODE_PLAIN  = 3'd3,
    MODE_QUOTED = 3'd4,
    MODE_ESC    = 3'd5
  } mode_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [1:0] role;
    logic       key_done;
    logic       key_dropped;
    logic       pair_done;
    logic       spec_done;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/key_value_spec_tokenizer_unit.sv =====
// Channel  Ports                                                Dir
// -------  ---------------------------------------------------  ---
// input    in_valid, in_stall, in_ch                            in
// result   out_valid, out_stall, out_char, out_role,            out
//          out_key_done, out_key_dropped, out_pair_done, out_spec_done
//
// One byte per cycle sustained while the result is not stalled; one result
// transaction per input transaction. Each byte passes the input register, then
// the result register, with the mode update between them.
// Synchronous active-low reset clears both valid flags and the mode to skipping.
// A stalled result holds; the input register still takes a byte while the
// result waits, and in_stall rises only when both registers are full.
`default_nettype none

module key_value_spec_tokenizer_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_char,
  output logic [1:0]      out_role,
  output logic            out_key_done,
  output logic            out_key_dropped,
  output logic            out_pair_done,
  output logic            out_spec_done
);
  import kvst_pkg::*;

  logic       fire;
  logic       out_free;
  logic [7:0] ch_q;
  result_t    res;
  result_t    res_q;

  kvst_in_reg u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .out_free (out_free),
    .fire     (fire),
    .ch_q     (ch_q)
  );

  kvst_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (ch_q),
    .res   (res)
  );

  kvst_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_q     (res_q)
  );

  assign out_char        = res_q.out_char;
  assign out_role        = res_q.role;
  assign out_key_done    = res_q.key_done;
  assign out_key_dropped = res_q.key_dropped;
  assign out_pair_done   = res_q.pair_done;
  assign out_spec_done   = res_q.spec_done;

endmodule

`default_nettype wire

// ===== hw/rtl/kvst_in_reg.sv =====
`default_nettype none

module kvst_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       out_free,
  output logic            fire,
  output logic [7:0]      ch_q
);
  import kvst_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] ch_r;
  logic       load;

  // Move the held byte on whenever the result register can take it.
  assign fire     = valid_r && out_free;
  assign in_stall = valid_r && !out_free;
  assign load     = in_valid && !in_stall;
  assign ch_q     = ch_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ch_r <= in_ch;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/kvst_scan.sv =====
`default_nettype none

`include "key_value_spec_tokenizer_unit_macros.svh"

module kvst_scan (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             fire,
  input  wire logic [7:0]       ch,
  output kvst_pkg::result_t     res
);
  import kvst_pkg::*;

  mode_t mode_r, mode_nxt;
  logic  is_nul, is_blank;

  assign is_nul   = (ch == CH_NUL);
  assign is_blank = (ch == CH_SPACE) || (ch == CH_TAB);

  always_comb begin
    mode_nxt = MODE_SKIP;
    case (mode_r)
      MODE_KEY: begin
        if (is_nul || is_blank) begin
          mode_nxt = MODE_SKIP;
        end else if (ch == CH_EQ) begin
          mode_nxt = MODE_VSTART;
        end else begin
          mode_nxt = MODE_KEY;
        end
      end
      MODE_VSTART: begin
        if (is_nul || is_blank) begin
          mode_nxt = MODE_SKIP;
        end else if (ch == CH_QUOTE) begin
          mode_nxt = MODE_QUOTED;
        end else begin
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_PLAIN: begin
        if (is_nul || is_blank) begin
          mode_nxt = MODE_SKIP;
        end else begin
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_QUOTED: begin
        if (is_nul || ch == CH_QUOTE) begin
          mode_nxt = MODE_SKIP;
        end else if (ch == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else begin
          mode_nxt = MODE_QUOTED;
        end
      end
      MODE_ESC: begin
        mode_nxt = is_nul ? MODE_SKIP : MODE_QUOTED;
      end
      default: begin
        if (is_nul || is_blank) begin
          mode_nxt = MODE_SKIP;
        end else if (ch == CH_EQ) begin
          mode_nxt = MODE_VSTART;
        end else begin
          mode_nxt = MODE_KEY;
        end
      end
    endcase
  end

  always_comb begin
    res           = '0;
    res.spec_done = is_nul;
    case (mode_r)
      MODE_KEY: begin
        if (is_nul || is_blank) begin
          res.key_dropped = 1'b1;
        end else if (ch == CH_EQ) begin
          res.key_done = 1'b1;
        end else begin
          res.out_char = ch;
          res.role     = ROLE_KEY;
        end
      end
      MODE_VSTART, MODE_PLAIN: begin
        if (is_nul || is_blank) begin
          res.pair_done = 1'b1;
        end else if (!(mode_r == MODE_VSTART && ch == CH_QUOTE)) begin
          res.out_char = ch;
          res.role     = ROLE_VALUE;
        end
      end
      MODE_QUOTED: begin
        if (is_nul || ch == CH_QUOTE) begin
          res.pair_done = 1'b1;
        end else if (ch != CH_BSLASH) begin
          res.out_char = ch;
          res.role     = ROLE_VALUE;
        end
      end
      MODE_ESC: begin
        // Escape cut off by the end: keep the backslash itself.
        res.out_char  = is_nul ? CH_BSLASH : ch;
        res.role      = ROLE_VALUE;
        res.pair_done = is_nul;
      end
      default: begin
        if (ch == CH_EQ) begin
          res.key_done = 1'b1;
        end else if (!is_nul && !is_blank) begin
          res.out_char = ch;
          res.role     = ROLE_KEY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_SKIP;
    end else if (fire) begin
      mode_r <= mode_nxt;
    end
  end

  `KVST_ASSERT_NOW(a_key_done_clean, res.key_done,
    res.role == ROLE_NONE && !res.pair_done && !res.key_dropped,
    "key_done with a kept byte or another flag")
  `KVST_ASSERT_NEXT(a_end_to_skip, fire && is_nul, mode_r == MODE_SKIP,
    "mode not back to skipping after end of spec")
  `KVST_ASSERT_NEXT(a_eq_to_vstart, fire && res.key_done, mode_r == MODE_VSTART,
    "mode not at value start after key_done")
  `KVST_ASSERT_NEXT(a_mode_hold, !fire, $stable(mode_r),
    "mode changed without a transaction")

endmodule

`default_nettype wire

// ===== hw/rtl/kvst_out_reg.sv =====
`default_nettype none

module kvst_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire kvst_pkg::result_t res,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kvst_pkg::result_t      res_q
);
  import kvst_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_comb begin
    valid_nxt = valid_r && out_stall;
    if (fire) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire
